// File: rtl/imhq_pkg.sv
// Package: types, widths and codes shared by the indexed min-heap queue.
package imhq_pkg;

    localparam int HEAP_DEPTH = 256;
    localparam int KEY_SPACE  = 1024;
    localparam int KEY_W      = 10;
    localparam int PRIO_W     = 32;
    localparam int POS_W      = $clog2(HEAP_DEPTH);
    localparam int CNT_W      = POS_W + 1;

    typedef enum logic [2:0] {
        REQ_SET    = 3'd0,
        REQ_PUSH   = 3'd1,
        REQ_UPDATE = 3'd2,
        REQ_POP    = 3'd3,
        REQ_QUERY  = 3'd4
    } req_code_t;

    typedef enum logic [1:0] {
        TAG_UNSEEN     = 2'd0,
        TAG_REMEMBERED = 2'd1,
        TAG_PRESENT    = 2'd2
    } key_tag_t;

    typedef struct packed {
        logic [KEY_W-1:0]         key;
        logic signed [PRIO_W-1:0] prio;
    } heap_entry_t;

    typedef struct packed {
        key_tag_t         tag;
        logic [POS_W-1:0] pos;
    } map_entry_t;

    typedef struct packed {
        logic             wr_en;
        logic [POS_W-1:0] wr_addr;
        heap_entry_t      wr_data;
        logic [POS_W-1:0] rd_addr;
    } heap_req_t;

    typedef struct packed {
        logic             wr_en;
        logic [KEY_W-1:0] wr_addr;
        map_entry_t       wr_data;
        logic [KEY_W-1:0] rd_addr;
    } map_req_t;

endpackage

// File: rtl/imhq_if.sv
// Interfaces: request and response channels of the indexed min-heap queue.
interface imhq_req_if
    import imhq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [2:0]               req_type;
    logic [KEY_W-1:0]         key;
    logic signed [PRIO_W-1:0] priority_req;
    logic                     flag;

    modport source (output valid, req_type, key, priority_req, flag, input ready);
    modport sink   (input valid, req_type, key, priority_req, flag, output ready);
endinterface

interface imhq_rsp_if
    import imhq_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic                     ok;
    logic [KEY_W-1:0]         key_out;
    logic signed [PRIO_W-1:0] priority_out;
    logic [CNT_W-1:0]         count;

    modport source (output valid, ok, key_out, priority_out, count, input ready);
    modport sink   (input valid, ok, key_out, priority_out, count, output ready);
endinterface

// File: rtl/imhq_heap_mem.sv
// Heap slot memory: one write port, one registered read port.
module imhq_heap_mem
    import imhq_pkg::*;
(
    input  logic        clk,
    input  heap_req_t   req,
    output heap_entry_t rd_data
);

    heap_entry_t mem [HEAP_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

// File: rtl/imhq_map_mem.sv
// Key position map memory: one write port, one registered read port.
module imhq_map_mem
    import imhq_pkg::*;
(
    input  logic       clk,
    input  map_req_t   req,
    output map_entry_t rd_data
);

    map_entry_t mem [KEY_SPACE];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

// File: rtl/imhq_ctrl.sv
// Sequencer: request decode, sift up/down with one shared comparator, result register.
module imhq_ctrl
    import imhq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    imhq_req_if.sink    req_ch,
    imhq_rsp_if.source  rsp_ch,
    output heap_req_t   heap_req,
    input  heap_entry_t heap_rd,
    output map_req_t    map_req,
    input  map_entry_t  map_rd
);

    typedef enum logic [15:0] {
        S_CLEAR  = 16'h0001,
        S_IDLE   = 16'h0002,
        S_LOOK   = 16'h0004,
        S_DECIDE = 16'h0008,
        S_POP_C  = 16'h0010,
        S_QRY_B  = 16'h0020,
        S_UPD_B  = 16'h0040,
        S_UPD_C  = 16'h0080,
        S_UP_A   = 16'h0100,
        S_UP_B   = 16'h0200,
        S_DN_A   = 16'h0400,
        S_DN_B   = 16'h0800,
        S_DN_C   = 16'h1000,
        S_DN_D   = 16'h2000,
        S_DONE   = 16'h4000
    } state_t;

    state_t                   state_reg, state_next;
    logic [KEY_W-1:0]         clr_reg, clr_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [2:0]               rtype_reg, rtype_next;
    logic                     flag_reg, flag_next;
    logic [KEY_W-1:0]         ik_reg, ik_next;
    logic signed [PRIO_W-1:0] ip_reg, ip_next;
    logic [POS_W-1:0]         pos_reg, pos_next;
    logic [POS_W-1:0]         cidx_reg, cidx_next;
    heap_entry_t              best_reg, best_next;
    logic [POS_W-1:0]         bidx_reg, bidx_next;
    logic signed [PRIO_W-1:0] old_reg, old_next;
    logic                     ok_reg, ok_next;
    logic [KEY_W-1:0]         kout_reg, kout_next;
    logic signed [PRIO_W-1:0] pout_reg, pout_next;
    logic                     ov_reg, ov_next;
    logic                     rok_reg, rok_next;
    logic [KEY_W-1:0]         rkey_reg, rkey_next;
    logic signed [PRIO_W-1:0] rprio_reg, rprio_next;
    logic [CNT_W-1:0]         rcnt_reg, rcnt_next;

    logic signed [PRIO_W-1:0] cmp_a, cmp_b;
    logic                     cmp_lt;
    logic [CNT_W-1:0]         child;
    logic [CNT_W-1:0]         child_r;
    logic [POS_W-1:0]         parent;
    logic                     push_ok;
    logic                     only_unknown;
    logic                     accept;

    assign cmp_lt  = cmp_a < cmp_b;
    assign child   = {pos_reg, 1'b1};
    assign child_r = {1'b0, cidx_reg} + CNT_W'(1);
    assign parent  = POS_W'((pos_reg - POS_W'(1)) >> 1);
    assign accept  = req_ch.valid && req_ch.ready;

    assign req_ch.ready        = (state_reg == S_IDLE);
    assign rsp_ch.valid        = ov_reg;
    assign rsp_ch.ok           = rok_reg;
    assign rsp_ch.key_out      = rkey_reg;
    assign rsp_ch.priority_out = rprio_reg;
    assign rsp_ch.count        = rcnt_reg;

    always_comb
    begin
        only_unknown = flag_reg;
        if (rtype_reg == REQ_UPDATE)
        begin
            only_unknown = 1'b0;
        end
        push_ok = !(map_rd.tag == TAG_PRESENT)
               && !(only_unknown && map_rd.tag == TAG_REMEMBERED)
               && !count_reg[CNT_W-1];
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        rtype_next = rtype_reg;
        flag_next  = flag_reg;
        ik_next    = ik_reg;
        ip_next    = ip_reg;
        pos_next   = pos_reg;
        cidx_next  = cidx_reg;
        best_next  = best_reg;
        bidx_next  = bidx_reg;
        old_next   = old_reg;
        ok_next    = ok_reg;
        kout_next  = kout_reg;
        pout_next  = pout_reg;
        ov_next    = ov_reg;
        rok_next   = rok_reg;
        rkey_next  = rkey_reg;
        rprio_next = rprio_reg;
        rcnt_next  = rcnt_reg;
        cmp_a      = ip_reg;
        cmp_b      = heap_rd.prio;

        heap_req         = '0;
        heap_req.wr_addr = pos_reg;
        heap_req.wr_data = '{key: ik_reg, prio: ip_reg};
        map_req          = '0;
        map_req.rd_addr  = ik_reg;
        map_req.wr_addr  = ik_reg;
        map_req.wr_data  = '{tag: TAG_PRESENT, pos: pos_reg};

        if (rsp_ch.valid && rsp_ch.ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = clr_reg;
                map_req.wr_data = '{tag: TAG_UNSEEN, pos: '0};
                clr_next        = clr_reg + KEY_W'(1);
                if (&clr_reg)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    rtype_next = req_ch.req_type;
                    flag_next  = req_ch.flag;
                    ik_next    = req_ch.key;
                    ip_next    = req_ch.priority_req;
                    ok_next    = 1'b0;
                    kout_next  = req_ch.key;
                    pout_next  = '0;
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                heap_req.rd_addr = '0;
                state_next       = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next = S_DONE;
                case (rtype_reg)
                    REQ_POP:
                    begin
                        if (count_reg != '0)
                        begin
                            kout_next        = heap_rd.key;
                            pout_next        = heap_rd.prio;
                            heap_req.rd_addr = POS_W'(count_reg - CNT_W'(1));
                            state_next       = S_POP_C;
                        end
                    end
                    REQ_QUERY:
                    begin
                        if (map_rd.tag == TAG_PRESENT)
                        begin
                            heap_req.rd_addr = map_rd.pos;
                            state_next       = S_QRY_B;
                        end
                    end
                    REQ_SET, REQ_PUSH, REQ_UPDATE:
                    begin
                        if (map_rd.tag == TAG_PRESENT && rtype_reg != REQ_PUSH)
                        begin
                            heap_req.rd_addr = map_rd.pos;
                            pos_next         = map_rd.pos;
                            state_next       = S_UPD_B;
                        end
                        else if (push_ok)
                        begin
                            count_next = count_reg + CNT_W'(1);
                            pos_next   = POS_W'(count_reg);
                            ok_next    = 1'b1;
                            state_next = S_UP_A;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_POP_C:
            begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = kout_reg;
                map_req.wr_data = '{tag: flag_reg ? TAG_REMEMBERED : TAG_UNSEEN, pos: '0};
                count_next      = count_reg - CNT_W'(1);
                ok_next         = 1'b1;
                ik_next         = heap_rd.key;
                ip_next         = heap_rd.prio;
                pos_next        = '0;
                state_next      = (count_reg == CNT_W'(1)) ? S_DONE : S_DN_A;
            end
            S_QRY_B:
            begin
                ok_next    = 1'b1;
                pout_next  = heap_rd.prio;
                state_next = S_DONE;
            end
            S_UPD_B:
            begin
                old_next = heap_rd.prio;
                if (cmp_lt)
                begin
                    ok_next    = 1'b1;
                    state_next = S_UP_A;
                end
                else
                begin
                    state_next = S_UPD_C;
                end
            end
            S_UPD_C:
            begin
                cmp_a = old_reg;
                cmp_b = ip_reg;
                if (cmp_lt && !flag_reg)
                begin
                    ok_next    = 1'b1;
                    state_next = S_DN_A;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_UP_A:
            begin
                if (pos_reg == '0)
                begin
                    heap_req.wr_en = 1'b1;
                    map_req.wr_en  = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    heap_req.rd_addr = parent;
                    state_next       = S_UP_B;
                end
            end
            S_UP_B:
            begin
                if (cmp_lt)
                begin
                    heap_req.wr_en   = 1'b1;
                    heap_req.wr_data = heap_rd;
                    map_req.wr_en    = 1'b1;
                    map_req.wr_addr  = heap_rd.key;
                    pos_next         = parent;
                    state_next       = S_UP_A;
                end
                else
                begin
                    heap_req.wr_en = 1'b1;
                    map_req.wr_en  = 1'b1;
                    state_next     = S_DONE;
                end
            end
            S_DN_A:
            begin
                if (child >= count_reg)
                begin
                    heap_req.wr_en = 1'b1;
                    map_req.wr_en  = 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    heap_req.rd_addr = child[POS_W-1:0];
                    cidx_next        = child[POS_W-1:0];
                    state_next       = S_DN_B;
                end
            end
            S_DN_B:
            begin
                best_next = heap_rd;
                bidx_next = cidx_reg;
                if (child_r < count_reg)
                begin
                    heap_req.rd_addr = child_r[POS_W-1:0];
                    state_next       = S_DN_C;
                end
                else
                begin
                    state_next = S_DN_D;
                end
            end
            S_DN_C:
            begin
                cmp_a = heap_rd.prio;
                cmp_b = best_reg.prio;
                if (cmp_lt)
                begin
                    best_next = heap_rd;
                    bidx_next = child_r[POS_W-1:0];
                end
                state_next = S_DN_D;
            end
            S_DN_D:
            begin
                cmp_a = best_reg.prio;
                cmp_b = ip_reg;
                heap_req.wr_en = 1'b1;
                map_req.wr_en  = 1'b1;
                if (cmp_lt)
                begin
                    heap_req.wr_data = best_reg;
                    map_req.wr_addr  = best_reg.key;
                    pos_next         = bidx_reg;
                    state_next       = S_DN_A;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!ov_reg || rsp_ch.ready)
                begin
                    ov_next    = 1'b1;
                    rok_next   = ok_reg;
                    rkey_next  = kout_reg;
                    rprio_next = pout_reg;
                    rcnt_next  = count_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rtype_reg <= rtype_next;
        flag_reg  <= flag_next;
        ik_reg    <= ik_next;
        ip_reg    <= ip_next;
        pos_reg   <= pos_next;
        cidx_reg  <= cidx_next;
        best_reg  <= best_next;
        bidx_reg  <= bidx_next;
        old_reg   <= old_next;
        ok_reg    <= ok_next;
        kout_reg  <= kout_next;
        pout_reg  <= pout_next;
        rok_reg   <= rok_next;
        rkey_reg  <= rkey_next;
        rprio_reg <= rprio_next;
        rcnt_reg  <= rcnt_next;
    end

endmodule

// File: rtl/indexed_min_heap_queue_top.sv
// Top level: indexed min-heap priority queue with per-key position map.
//
// Handles one request at a time; ready is low while a request is in work.
// A request passes lookup, decode and result hand-off, plus the sift in
// the 256-entry heap: each level moved up steps through S_UP_A and S_UP_B,
// each level moved down through S_DN_A to S_DN_D (S_DN_C only with a right
// child). The single read port of the heap slot memory and the one shared
// priority comparator set the per-level cost. After reset the key map is
// cleared one entry per cycle, all 1024 entries, before the first request
// beat is taken. A finished result waits in an output register, so the next request can start meanwhile.
module indexed_min_heap_queue_top
    import imhq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    imhq_req_if.sink   req_ch,
    imhq_rsp_if.source rsp_ch
);

    heap_req_t   heap_req;
    heap_entry_t heap_rd;
    map_req_t    map_req;
    map_entry_t  map_rd;

    imhq_heap_mem u_heap_mem (
        .clk     (clk),
        .req     (heap_req),
        .rd_data (heap_rd)
    );

    imhq_map_mem u_map_mem (
        .clk     (clk),
        .req     (map_req),
        .rd_data (map_rd)
    );

    imhq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_ch   (req_ch),
        .rsp_ch   (rsp_ch),
        .heap_req (heap_req),
        .heap_rd  (heap_rd),
        .map_req  (map_req),
        .map_rd   (map_rd)
    );

endmodule

// File: test/imhq_scoreboard.sv
// Scoreboard: predicts the indexed min-heap queue and checks its responses.
class imhq_scoreboard;
    typedef struct {
        logic                     ok;
        logic [9:0]               key_out;
        logic signed [31:0]       priority_out;
        logic [8:0]               count;
    } rsp_beat_t;

    logic [9:0]         slot_key [256];
    logic signed [31:0] slot_prio [256];
    logic [1:0]         key_state [1024];
    int unsigned        key_slot [1024];
    int unsigned        fill;
    rsp_beat_t          pending [$];
    int                 errors;

    function new();
        foreach (key_state[i])
        begin
            key_state[i] = imhq_pkg::TAG_UNSEEN;
            key_slot[i] = 0;
        end
        fill = 0;
        errors = 0;
    endfunction

    function void put_slot(int unsigned s, logic [9:0] k, logic signed [31:0] p);
        slot_key[s] = k;
        slot_prio[s] = p;
        key_state[k] = imhq_pkg::TAG_PRESENT;
        key_slot[k] = s;
    endfunction

    function void sift_up(int unsigned s);
        logic [9:0]         k;
        logic signed [31:0] p;
        int unsigned        par;
        k = slot_key[s];
        p = slot_prio[s];
        while (s > 0)
        begin
            par = (s - 1) / 2;
            if (!(p < slot_prio[par]))
                break;
            put_slot(s, slot_key[par], slot_prio[par]);
            s = par;
        end
        put_slot(s, k, p);
    endfunction

    function void settle_down(int unsigned s);
        logic [9:0]         k;
        logic signed [31:0] p;
        int unsigned        ch;
        k = slot_key[s];
        p = slot_prio[s];
        forever
        begin
            ch = 2 * s + 1;
            if (ch >= fill)
                break;
            if (ch + 1 < fill && slot_prio[ch + 1] < slot_prio[ch])
                ch++;
            if (!(slot_prio[ch] < p))
                break;
            put_slot(s, slot_key[ch], slot_prio[ch]);
            s = ch;
        end
        put_slot(s, k, p);
    endfunction

    function bit insert_key(logic [9:0] k, logic signed [31:0] p, bit only_unknown);
        if (key_state[k] == imhq_pkg::TAG_PRESENT)
            return 0;
        if (only_unknown && key_state[k] == imhq_pkg::TAG_REMEMBERED)
            return 0;
        if (fill >= 256)
            return 0;
        fill++;
        put_slot(fill - 1, k, p);
        sift_up(fill - 1);
        return 1;
    endfunction

    function bit change_key(logic [9:0] k, logic signed [31:0] p, bit only_lower);
        int unsigned s;
        if (key_state[k] != imhq_pkg::TAG_PRESENT)
            return insert_key(k, p, 0);
        s = key_slot[k];
        if (p < slot_prio[s])
        begin
            slot_prio[s] = p;
            sift_up(s);
            return 1;
        end
        if (!only_lower && p > slot_prio[s])
        begin
            slot_prio[s] = p;
            settle_down(s);
            return 1;
        end
        return 0;
    endfunction

    function void note_request(logic [2:0] op, logic [9:0] k, logic signed [31:0] p, bit f);
        rsp_beat_t r;
        r.ok = 0;
        r.key_out = k;
        r.priority_out = 0;
        case (op)
            imhq_pkg::REQ_SET:
                r.ok = (key_state[k] == imhq_pkg::TAG_PRESENT) ? change_key(k, p, f)
                                                               : insert_key(k, p, f);
            imhq_pkg::REQ_PUSH:   r.ok = insert_key(k, p, f);
            imhq_pkg::REQ_UPDATE: r.ok = change_key(k, p, f);
            imhq_pkg::REQ_POP:
                if (fill > 0)
                begin
                    r.key_out = slot_key[0];
                    r.priority_out = slot_prio[0];
                    key_state[slot_key[0]] = f ? imhq_pkg::TAG_REMEMBERED
                                               : imhq_pkg::TAG_UNSEEN;
                    fill--;
                    if (fill > 0)
                    begin
                        put_slot(0, slot_key[fill], slot_prio[fill]);
                        settle_down(0);
                    end
                    r.ok = 1;
                end
            imhq_pkg::REQ_QUERY:
                if (key_state[k] == imhq_pkg::TAG_PRESENT)
                begin
                    r.ok = 1;
                    r.priority_out = slot_prio[key_slot[k]];
                end
            default: ;
        endcase
        r.count = fill[8:0];
        pending.push_back(r);
    endfunction

    function void check_response(logic ok, logic [9:0] ko, logic signed [31:0] po,
                                 logic [8:0] cnt);
        rsp_beat_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected response beat");
            errors++;
            return;
        end
        e = pending.pop_front();
        if (ok !== e.ok)
        begin
            $error("ok: expected %0d actual %0d", e.ok, ok);
            errors++;
        end
        if (ko !== e.key_out)
        begin
            $error("key_out: expected %0d actual %0d", e.key_out, ko);
            errors++;
        end
        if (po !== e.priority_out)
        begin
            $error("priority_out: expected %0d actual %0d", e.priority_out, po);
            errors++;
        end
        if (cnt !== e.count)
        begin
            $error("count: expected %0d actual %0d", e.count, cnt);
            errors++;
        end
    endfunction
endclass

// File: test/tb.sv
// Testbench top: drives requests into the heap queue and checks every response.
module tb
    import imhq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    int   cycle;
    bit   calm;
    bit   long_hold;
    int   sent;

    imhq_req_if req_ch ();
    imhq_rsp_if rsp_ch ();

    imhq_scoreboard heap_model;

    indexed_min_heap_queue_top u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch.sink),
        .rsp_ch (rsp_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic send_beat(logic [2:0] op, logic [9:0] k, logic signed [31:0] p, bit f);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 9);
            req_ch.valid <= 0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1;
        req_ch.req_type <= op;
        req_ch.key <= k;
        req_ch.priority_req <= p;
        req_ch.flag <= f;
        do
            @(posedge clk);
        while (!req_ch.ready);
        heap_model.note_request(op, k, p, f);
        sent++;
    endtask

    function automatic logic signed [31:0] pick_prio();
        case ($urandom_range(0, 5))
            0: return 32'sh8000_0000;
            1: return 32'sh7fff_ffff;
            2: return $urandom();
            default: return $signed($urandom_range(0, 60)) - 30;
        endcase
    endfunction

    task automatic random_beat(int key_span);
        logic [2:0] op;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 22)
            op = REQ_SET;
        else if (r < 44)
            op = REQ_PUSH;
        else if (r < 60)
            op = REQ_UPDATE;
        else if (r < 82)
            op = REQ_POP;
        else if (r < 97)
            op = REQ_QUERY;
        else
            op = 3'($urandom_range(5, 7));
        send_beat(op, 10'($urandom_range(0, key_span)), pick_prio(), 1'($urandom()));
    endtask

    initial
    begin
        req_ch.valid = 0;
        req_ch.req_type = REQ_QUERY;
        req_ch.key = 0;
        req_ch.priority_req = 0;
        req_ch.flag = 0;
        heap_model = new();
        calm = 0;
        sent = 0;
        rst_n = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        send_beat(REQ_POP, 10'd1023, 0, 0);
        send_beat(REQ_QUERY, 10'd5, 0, 0);
        send_beat(REQ_PUSH, 10'd0, 32'sh7fff_ffff, 0);
        send_beat(REQ_PUSH, 10'd1023, 32'sh8000_0000, 1);
        send_beat(REQ_PUSH, 10'd0, 5, 0);
        send_beat(REQ_SET, 10'd7, 10, 0);
        send_beat(REQ_SET, 10'd7, 3, 1);
        send_beat(REQ_SET, 10'd7, 20, 1);
        send_beat(REQ_UPDATE, 10'd7, 20, 0);
        send_beat(REQ_UPDATE, 10'd7, 20, 0);
        send_beat(REQ_UPDATE, 10'd9, -4, 1);
        send_beat(REQ_QUERY, 10'd9, 0, 0);
        send_beat(REQ_POP, 10'd0, 0, 1);
        send_beat(REQ_PUSH, 10'd1023, 1, 1);
        send_beat(REQ_SET, 10'd1023, 1, 1);
        send_beat(REQ_PUSH, 10'd1023, 2, 0);
        send_beat(REQ_POP, 10'd0, 0, 0);
        send_beat(3'd5, 10'd3, -1, 1);
        send_beat(3'd7, 10'd3, -1, 0);
        for (int i = 0; i < 270; i++)
            send_beat(REQ_PUSH, 10'(i + 100), pick_prio(), 0);
        for (int i = 0; i < 40; i++)
            random_beat(1023);
        for (int i = 0; i < 280; i++)
            send_beat(REQ_POP, 10'($urandom()), 0, 1'($urandom()));
        for (int i = 0; i < 1040; i++)
            random_beat((i % 400 < 200) ? 40 : 1023);
        calm = 1;
        for (int i = 0; i < 200; i++)
            random_beat(60);
        req_ch.valid <= 0;
    end

    initial
    begin
        int gap;
        rsp_ch.ready = 0;
        long_hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
                heap_model.check_response(rsp_ch.ok, rsp_ch.key_out, rsp_ch.priority_out,
                                          rsp_ch.count);
            if (!long_hold && sent > 300)
            begin
                long_hold = 1;
                rsp_ch.ready <= 0;
                repeat (300) @(posedge clk);
                rsp_ch.ready <= 1;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                gap = $urandom_range(1, 9);
                rsp_ch.ready <= 0;
                repeat (gap) @(posedge clk);
                rsp_ch.ready <= 1;
            end
            else
                rsp_ch.ready <= 1;
        end
    end

    initial
    begin
        cycle = 0;
        forever
        begin
            @(posedge clk);
            cycle++;
            if (cycle > 400000)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial
    begin
        wait (sent == 1849);
        while (heap_model.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (heap_model.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
